>>> src/aeg_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// aeg_pkg
// Shared constants, codes and types of the ADSR envelope generator.
// ============================================================================
package aeg_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int GAIN_BITS      = GAIN_FRAC_BITS + 1;
    localparam int COUNT_BITS     = 16;
    localparam int LEN_BITS       = 16;
    localparam int STEP_BITS      = 32;
    localparam int OPCODE_BITS    = 2;
    localparam int PHASE_BITS     = 3;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 17;

    localparam int MUL_BITS      = LEN_BITS + STEP_BITS;
    localparam int SCALE_BITS    = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int DIVIDEND_BITS = GAIN_BITS + GAIN_FRAC_BITS;
    localparam int DIV_STEPS     = DIVIDEND_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC_BITS;

    localparam logic [LEN_BITS-1:0]  ATTACK_RESET  = LEN_BITS'(11025);
    localparam logic [LEN_BITS-1:0]  DECAY_RESET   = LEN_BITS'(10000);
    localparam logic [GAIN_BITS-1:0] SUSTAIN_RESET = GAIN_BITS'(32768);
    localparam logic [LEN_BITS-1:0]  RELEASE_RESET = LEN_BITS'(15000);

    localparam logic [OPCODE_BITS-1:0] OP_SAMPLE   = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [PHASE_BITS-1:0] SEG_IDLE    = 3'd0;
    localparam logic [PHASE_BITS-1:0] SEG_ATTACK  = 3'd1;
    localparam logic [PHASE_BITS-1:0] SEG_DECAY   = 3'd2;
    localparam logic [PHASE_BITS-1:0] SEG_SUSTAIN = 3'd3;
    localparam logic [PHASE_BITS-1:0] SEG_RELEASE = 3'd4;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ATTACK  = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY   = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SUSTAIN = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE = 4'd3;

    typedef struct packed {
        logic load_in;
        logic mul_en;
        logic div_load;
        logic div_step;
        logic gain_en;
        logic scale_en;
        logic commit;
    } cmd_t;

endpackage

>>> src/aeg_divider.sv
`timescale 1ns / 1ps
// ============================================================================
// aeg_divider
// Restoring divider, one quotient bit per step.
// ============================================================================
module aeg_divider (
    input  logic                                aclk,
    input  logic                                load,
    input  logic                                step,
    input  logic [aeg_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  logic [aeg_pkg::LEN_BITS-1:0]        divisor,
    output logic [aeg_pkg::DIVIDEND_BITS-1:0]   quotient
);

    logic [aeg_pkg::DIVIDEND_BITS-1:0] quo_reg;
    logic [aeg_pkg::DIVIDEND_BITS-1:0] quo_next;
    logic [aeg_pkg::LEN_BITS-1:0]      rem_reg;
    logic [aeg_pkg::LEN_BITS-1:0]      rem_next;
    logic [aeg_pkg::LEN_BITS-1:0]      den_reg;
    logic [aeg_pkg::LEN_BITS:0]        trial;
    logic [aeg_pkg::LEN_BITS:0]        diff;
    logic                              fits;

    assign trial = {rem_reg, quo_reg[aeg_pkg::DIVIDEND_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    assign quo_next = {quo_reg[aeg_pkg::DIVIDEND_BITS-2:0], fits};
    assign rem_next = fits ? diff[aeg_pkg::LEN_BITS-1:0] : trial[aeg_pkg::LEN_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> src/aeg_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// aeg_datapath
// Envelope state, configuration registers, ramp arithmetic and output register.
// ============================================================================
module aeg_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  aeg_pkg::cmd_t                           cmd,
    input  logic                                    cfg_valid,
    input  logic [aeg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [aeg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic [aeg_pkg::OPCODE_BITS-1:0]         s_opcode,
    input  logic signed [aeg_pkg::SAMPLE_BITS-1:0]  s_sample_in,
    output logic signed [aeg_pkg::SAMPLE_BITS-1:0]  m_sample_out,
    output logic                                    m_voice_done,
    output logic [aeg_pkg::PHASE_BITS-1:0]          m_phase
);

    localparam int LB = aeg_pkg::LEN_BITS;
    localparam int GB = aeg_pkg::GAIN_BITS;
    localparam int FB = aeg_pkg::GAIN_FRAC_BITS;
    localparam int SB = aeg_pkg::STEP_BITS;
    localparam int CB = aeg_pkg::COUNT_BITS;
    localparam int MB = aeg_pkg::MUL_BITS;
    localparam int XB = aeg_pkg::SCALE_BITS;
    localparam int DB = aeg_pkg::DIVIDEND_BITS;
    localparam int PB = aeg_pkg::PHASE_BITS;
    localparam int NB = aeg_pkg::SAMPLE_BITS;

    logic [LB-1:0] attack_len_reg;
    logic [LB-1:0] decay_len_reg;
    logic [GB-1:0] sustain_reg;
    logic [LB-1:0] release_len_reg;

    logic [PB-1:0] segment_reg;
    logic [PB-1:0] segment_next;
    logic [CB-1:0] count_reg;
    logic [CB-1:0] count_next;
    logic [GB-1:0] held_reg;
    logic [GB-1:0] held_next;
    logic [SB-1:0] step_reg;
    logic [SB-1:0] step_next;
    logic          done_reg;
    logic          done_next;

    logic [aeg_pkg::OPCODE_BITS-1:0] op_reg;
    logic signed [NB-1:0]            sample_reg;
    logic [MB-1:0]                   mul_reg;
    logic [MB-1:0]                   mul_next;
    logic [GB-1:0]                   gain_reg;
    logic [GB-1:0]                   gain_next;
    logic signed [XB-1:0]            scale_reg;
    logic signed [XB-1:0]            scale_next;
    logic signed [NB-1:0]            y_next;

    logic [LB-1:0] lim_attack;
    logic [LB-1:0] lim_decay;
    logic [GB-1:0] sustain_eff;
    logic [GB-1:0] span;
    logic          is_decay;
    logic [LB-1:0] mul_a;
    logic [SB-1:0] mul_b;
    logic [SB-1:0] release_dec;
    logic [SB-1:0] step_new;

    logic [DB-1:0] div_dividend;
    logic [LB-1:0] div_divisor;
    logic [DB-1:0] quotient;

    assign lim_attack  = (count_reg > attack_len_reg) ? attack_len_reg : count_reg;
    assign lim_decay   = (count_reg > decay_len_reg) ? decay_len_reg : count_reg;
    assign sustain_eff = (sustain_reg > aeg_pkg::GAIN_ONE) ? aeg_pkg::GAIN_ONE : sustain_reg;
    assign span        = aeg_pkg::GAIN_ONE - sustain_eff;
    assign is_decay    = (op_reg == aeg_pkg::OP_SAMPLE) && (segment_reg == aeg_pkg::SEG_DECAY);

    assign mul_a    = is_decay ? lim_decay : count_reg;
    assign mul_b    = is_decay ? SB'(span) : step_reg;
    assign mul_next = MB'(mul_a) * MB'(mul_b);

    always_comb begin
        div_dividend = '0;
        div_divisor  = attack_len_reg;
        if (op_reg == aeg_pkg::OP_NOTE_OFF) begin
            div_dividend = {held_reg, FB'(0)};
            div_divisor  = release_len_reg;
        end else if (op_reg == aeg_pkg::OP_SAMPLE) begin
            case (segment_reg)
                aeg_pkg::SEG_ATTACK: begin
                    div_dividend = {1'b0, lim_attack, FB'(0)};
                    div_divisor  = attack_len_reg;
                end
                aeg_pkg::SEG_DECAY: begin
                    div_dividend = mul_reg[DB-1:0];
                    div_divisor  = decay_len_reg;
                end
                default: begin
                    div_dividend = '0;
                end
            endcase
        end
    end

    aeg_divider u_aeg_divider (
        .aclk     (aclk),
        .load     (cmd.div_load),
        .step     (cmd.div_step),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (quotient)
    );

    assign release_dec = mul_reg[MB-1:FB];

    always_comb begin
        case (segment_reg)
            aeg_pkg::SEG_ATTACK: begin
                gain_next = (attack_len_reg == '0) ? '0 : quotient[GB-1:0];
            end
            aeg_pkg::SEG_DECAY: begin
                gain_next = (decay_len_reg == '0) ? aeg_pkg::GAIN_ONE
                                                  : aeg_pkg::GAIN_ONE - quotient[GB-1:0];
            end
            aeg_pkg::SEG_SUSTAIN: begin
                gain_next = sustain_eff;
            end
            aeg_pkg::SEG_RELEASE: begin
                gain_next = (release_dec >= SB'(held_reg)) ? '0
                                                           : held_reg - release_dec[GB-1:0];
            end
            default: begin
                gain_next = '0;
            end
        endcase
    end

    assign scale_next = XB'(sample_reg) * XB'($signed({1'b0, gain_reg}));

    assign step_new = (release_len_reg == '0) ? '0 :
                      (quotient[DB-1:SB] != '0) ? '1 : quotient[SB-1:0];

    always_comb begin
        segment_next = segment_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        step_next    = step_reg;
        done_next    = done_reg;
        y_next       = '0;
        case (op_reg)
            aeg_pkg::OP_NOTE_ON: begin
                count_next   = '0;
                done_next    = 1'b0;
                segment_next = aeg_pkg::SEG_ATTACK;
            end
            aeg_pkg::OP_NOTE_OFF: begin
                step_next    = step_new;
                count_next   = '0;
                segment_next = aeg_pkg::SEG_RELEASE;
            end
            aeg_pkg::OP_SAMPLE: begin
                case (segment_reg)
                    aeg_pkg::SEG_ATTACK: begin
                        held_next = gain_reg;
                        y_next    = scale_reg[FB+NB-1:FB];
                        if (count_reg >= attack_len_reg) begin
                            count_next   = '0;
                            segment_next = aeg_pkg::SEG_DECAY;
                        end else begin
                            count_next = count_reg + CB'(1);
                        end
                    end
                    aeg_pkg::SEG_DECAY: begin
                        held_next = gain_reg;
                        y_next    = scale_reg[FB+NB-1:FB];
                        if (count_reg >= decay_len_reg) begin
                            count_next   = '0;
                            segment_next = aeg_pkg::SEG_SUSTAIN;
                        end else begin
                            count_next = count_reg + CB'(1);
                        end
                    end
                    aeg_pkg::SEG_SUSTAIN: begin
                        held_next = gain_reg;
                        y_next    = scale_reg[FB+NB-1:FB];
                    end
                    aeg_pkg::SEG_RELEASE: begin
                        y_next = scale_reg[FB+NB-1:FB];
                        if (count_reg >= release_len_reg) begin
                            count_next   = '0;
                            segment_next = aeg_pkg::SEG_IDLE;
                        end else begin
                            count_next = count_reg + CB'(1);
                        end
                    end
                    default: begin
                        done_next = 1'b1;
                    end
                endcase
            end
            default: begin
                y_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_len_reg  <= aeg_pkg::ATTACK_RESET;
            decay_len_reg   <= aeg_pkg::DECAY_RESET;
            sustain_reg     <= aeg_pkg::SUSTAIN_RESET;
            release_len_reg <= aeg_pkg::RELEASE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                aeg_pkg::CFG_ATTACK:  attack_len_reg  <= cfg_data[LB-1:0];
                aeg_pkg::CFG_DECAY:   decay_len_reg   <= cfg_data[LB-1:0];
                aeg_pkg::CFG_SUSTAIN: sustain_reg     <= cfg_data[GB-1:0];
                aeg_pkg::CFG_RELEASE: release_len_reg <= cfg_data[LB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            segment_reg <= aeg_pkg::SEG_IDLE;
            count_reg   <= '0;
            held_reg    <= '0;
            step_reg    <= '0;
            done_reg    <= 1'b0;
        end else if (cmd.commit) begin
            segment_reg <= segment_next;
            count_reg   <= count_next;
            held_reg    <= held_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg     <= s_opcode;
            sample_reg <= s_sample_in;
        end
        if (cmd.mul_en) begin
            mul_reg <= mul_next;
        end
        if (cmd.gain_en) begin
            gain_reg <= gain_next;
        end
        if (cmd.scale_en) begin
            scale_reg <= scale_next;
        end
        if (cmd.commit) begin
            m_sample_out <= y_next;
            m_voice_done <= done_next;
            m_phase      <= segment_next;
        end
    end

endmodule

>>> src/aeg_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// aeg_controller
// Sequencer for one transaction: multiply, divide, gain, scale, commit.
// ============================================================================
module aeg_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output aeg_pkg::cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIVLD  = 3'd2;
    localparam logic [2:0] ST_DIV    = 3'd3;
    localparam logic [2:0] ST_GAIN   = 3'd4;
    localparam logic [2:0] ST_SCALE  = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    localparam logic [aeg_pkg::DIV_CNT_BITS-1:0] DIV_LAST =
        aeg_pkg::DIV_CNT_BITS'(aeg_pkg::DIV_STEPS - 1);

    logic [2:0]                      state_reg;
    logic [2:0]                      state_next;
    logic [aeg_pkg::DIV_CNT_BITS-1:0] cnt_reg;
    logic [aeg_pkg::DIV_CNT_BITS-1:0] cnt_next;
    logic                            m_valid_reg;
    logic                            m_valid_next;
    logic                            out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = ST_DIVLD;
            end
            ST_DIVLD: begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_GAIN;
                end else begin
                    cnt_next = cnt_reg + aeg_pkg::DIV_CNT_BITS'(1);
                end
            end
            ST_GAIN: begin
                cmd.gain_en = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE: begin
                cmd.scale_en = 1'b1;
                state_next   = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> src/adsr_envelope_generator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// adsr_envelope_generator_core
// Linear ADSR envelope for one voice with a serial divider.
// ============================================================================
// Usage:
//   Input channel (s_valid/s_ready) carries an opcode and a Q1.15 sample:
//   scale a sample, note on, or note off. Every input transaction yields
//   exactly one result transaction on the m_ channel: the scaled sample
//   (zero for note events and idle), the done flag and the phase.
//   Configuration channel (cfg_valid/cfg_ready) writes attack, decay,
//   sustain and release registers by index; cfg_ready is always high.
//   Write configuration only while no transaction is in flight.
//   A new input is accepted only after the previous transaction commits;
//   the 33-step restoring divider takes most of each transaction.
//   s_ready is high only between transactions; a finished result waits
//   in the output register while the next input is accepted. If the
//   receiver stalls, the commit holds until the output register frees.
//   Reset (synchronous, active low) restores default lengths and sustain,
//   sets phase idle, clears counters, held gain, step and the done flag.
// ============================================================================
module adsr_envelope_generator_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [aeg_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [aeg_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [aeg_pkg::OPCODE_BITS-1:0]         s_opcode,
    input  logic signed [aeg_pkg::SAMPLE_BITS-1:0]  s_sample_in,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [aeg_pkg::SAMPLE_BITS-1:0]  m_sample_out,
    output logic                                    m_voice_done,
    output logic [aeg_pkg::PHASE_BITS-1:0]          m_phase
);

    aeg_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    aeg_controller u_aeg_controller (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    aeg_datapath u_aeg_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_opcode     (s_opcode),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .m_voice_done (m_voice_done),
        .m_phase      (m_phase)
    );

endmodule

>>> src/aeg_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// aeg_checker
// Port-level checks of the envelope generator, bound to the top level.
// ============================================================================
module aeg_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [aeg_pkg::SAMPLE_BITS-1:0]  m_sample_out,
    input logic                                    m_voice_done,
    input logic [aeg_pkg::PHASE_BITS-1:0]          m_phase
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
            && $stable(m_voice_done) && $stable(m_phase))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    a_ready_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("new result without returning to accept input");

    a_done_clear_in_note: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_phase == aeg_pkg::SEG_ATTACK || m_phase == aeg_pkg::SEG_DECAY
            || m_phase == aeg_pkg::SEG_SUSTAIN) |-> !m_voice_done)
        else $error("done flag set while note is held");

endmodule

bind adsr_envelope_generator_core aeg_checker u_aeg_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the ADSR envelope generator core. A short table of
// directed transactions and register writes covers reset behavior, zero and
// full-length segments, sustain saturation, lengths lowered mid-segment and
// the unused opcode. Random phases follow: each one reprograms the envelope
// while the core is idle, then plays note-on / sample / note-off sequences
// with some noise mixed in. Every result is checked against the table's own
// expected values where a row gives them, else a local model of the envelope,
// with random idling on both sides and long receiver hold-offs.
// ============================================================================
module testbench;
    import aeg_pkg::*;

    localparam logic [OPCODE_BITS-1:0]    OP_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 4'd15;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int TARGET_EVENTS  = 1250;
    localparam int RUN_CAP        = 30;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          voice_done;
        logic [PHASE_BITS-1:0]         phase;
    } env_result_t;

    typedef struct packed {
        logic                      is_cfg;
        logic [CFG_INDEX_BITS-1:0] sel;
        logic [CFG_DATA_BITS-1:0]  data;
        logic                      typed_want;
        env_result_t               want;
    } dir_row_t;

    localparam env_result_t NO_RESULT = '0;

    localparam int DIRECTED_ROWS = 38;
    localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b1, '{16'h0000, 1'b1, SEG_IDLE}},
        '{1'b0, 4'(OP_NOTE_OFF), 17'h00000, 1'b1, '{16'h0000, 1'b1, SEG_RELEASE}},
        '{1'b0, 4'(OP_SAMPLE),   17'h08000, 1'b1, '{16'h0000, 1'b1, SEG_RELEASE}},
        '{1'b0, 4'(OP_UNUSED),   17'h01234, 1'b1, '{16'h0000, 1'b1, SEG_RELEASE}},
        '{1'b1, CFG_ATTACK,      17'h00000, 1'b0, NO_RESULT},
        '{1'b1, CFG_DECAY,       17'h00000, 1'b0, NO_RESULT},
        '{1'b1, CFG_SUSTAIN,     17'h1FFFF, 1'b0, NO_RESULT},
        '{1'b1, CFG_RELEASE,     17'h00000, 1'b0, NO_RESULT},
        '{1'b1, CFG_UNUSED,      17'h1FFFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_NOTE_ON),  17'h07FFF, 1'b1, '{16'h0000, 1'b0, SEG_ATTACK}},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b1, '{16'h0000, 1'b0, SEG_DECAY}},
        '{1'b0, 4'(OP_SAMPLE),   17'h08000, 1'b1, '{16'h8000, 1'b0, SEG_SUSTAIN}},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b1, '{16'h7FFF, 1'b0, SEG_SUSTAIN}},
        '{1'b0, 4'(OP_NOTE_OFF), 17'h0FFFF, 1'b1, '{16'h0000, 1'b0, SEG_RELEASE}},
        '{1'b0, 4'(OP_SAMPLE),   17'h0FFFF, 1'b1, '{16'hFFFF, 1'b0, SEG_IDLE}},
        '{1'b0, 4'(OP_SAMPLE),   17'h00005, 1'b1, '{16'h0000, 1'b1, SEG_IDLE}},
        '{1'b1, CFG_ATTACK,      17'h0FFFF, 1'b0, NO_RESULT},
        '{1'b1, CFG_DECAY,       17'h00004, 1'b0, NO_RESULT},
        '{1'b1, CFG_SUSTAIN,     17'h00000, 1'b0, NO_RESULT},
        '{1'b1, CFG_RELEASE,     17'h0FFFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_NOTE_ON),  17'h00000, 1'b1, '{16'h0000, 1'b0, SEG_ATTACK}},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h04000, 1'b0, NO_RESULT},
        '{1'b1, CFG_ATTACK,      17'h00001, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h0D431, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h05555, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_NOTE_OFF), 17'h00000, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h0AAAA, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b0, NO_RESULT},
        '{1'b1, CFG_RELEASE,     17'h00001, 1'b0, NO_RESULT},
        '{1'b1, CFG_SUSTAIN,     17'h10000, 1'b0, NO_RESULT},
        '{1'b1, CFG_DECAY,       17'h0FFFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h08000, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h00001, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_NOTE_ON),  17'h00000, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b0, NO_RESULT},
        '{1'b0, 4'(OP_SAMPLE),   17'h07FFF, 1'b0, NO_RESULT}
    };

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          cfg_valid      = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_BITS-1:0]     cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]      cfg_data       = '0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [OPCODE_BITS-1:0]        s_opcode       = OP_SAMPLE;
    logic signed [SAMPLE_BITS-1:0] s_sample_in    = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_sample_out;
    logic                          m_voice_done;
    logic [PHASE_BITS-1:0]         m_phase;

    // envelope model state and registers
    logic [LEN_BITS-1:0]   atk_len       = ATTACK_RESET;
    logic [LEN_BITS-1:0]   dec_len       = DECAY_RESET;
    logic [GAIN_BITS-1:0]  sustain_reg   = SUSTAIN_RESET;
    logic [LEN_BITS-1:0]   rel_len       = RELEASE_RESET;
    logic [PHASE_BITS-1:0] env_segment   = SEG_IDLE;
    logic [COUNT_BITS-1:0] env_count     = '0;
    logic [GAIN_BITS-1:0]  env_held      = '0;
    logic [STEP_BITS-1:0]  env_step      = '0;
    logic                  env_done      = 1'b0;

    env_result_t results_due[$];
    int          mismatches   = 0;
    int          events_sent  = 0;
    int          quiet_cycles = 0;
    bit          no_gaps      = 1'b0;
    bit          rx_hold_req  = 1'b0;

    adsr_envelope_generator_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_voice_done (m_voice_done),
        .m_phase      (m_phase)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] clamp_count(logic [63:0] c, logic [63:0] len);
        return (c > len) ? len : c;
    endfunction

    function automatic logic [63:0] sustain_cap();
        return (sustain_reg > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(sustain_reg);
    endfunction

    function automatic bit count_through(logic [63:0] len);
        if (64'(env_count) >= len) begin
            env_count = '0;
            return 1'b1;
        end
        env_count = env_count + 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] apply_gain(logic signed [SAMPLE_BITS-1:0] smp,
                                                         logic [63:0] gain);
        logic signed [63:0] s64;
        logic signed [63:0] prod;
        s64  = smp;
        prod = s64 * $signed(gain);
        return SAMPLE_BITS'(prod >>> GAIN_FRAC_BITS);
    endfunction

    function automatic env_result_t envelope_step(logic [OPCODE_BITS-1:0] op,
                                                  logic [SAMPLE_BITS-1:0] smp);
        env_result_t r;
        logic [63:0] gain;
        logic [63:0] span;
        logic [63:0] drop;
        logic [63:0] quot;
        gain         = '0;
        r.sample_out = '0;
        case (op)
            OP_NOTE_ON: begin
                env_count   = '0;
                env_done    = 1'b0;
                env_segment = SEG_ATTACK;
            end
            OP_NOTE_OFF: begin
                if (rel_len == 0) begin
                    env_step = '0;
                end else begin
                    quot     = (64'(env_held) << GAIN_FRAC_BITS) / 64'(rel_len);
                    env_step = (quot > 64'hFFFF_FFFF) ? '1 : quot[STEP_BITS-1:0];
                end
                env_count   = '0;
                env_segment = SEG_RELEASE;
            end
            OP_SAMPLE: begin
                case (env_segment)
                    SEG_ATTACK: begin
                        if (atk_len != 0)
                            gain = (clamp_count(64'(env_count), 64'(atk_len))
                                    << GAIN_FRAC_BITS) / 64'(atk_len);
                        env_held     = gain[GAIN_BITS-1:0];
                        r.sample_out = apply_gain(smp, gain);
                        if (count_through(64'(atk_len)))
                            env_segment = SEG_DECAY;
                    end
                    SEG_DECAY: begin
                        span = 64'(GAIN_ONE) - sustain_cap();
                        gain = 64'(GAIN_ONE);
                        if (dec_len != 0)
                            gain = gain - (clamp_count(64'(env_count), 64'(dec_len)) * span)
                                          / 64'(dec_len);
                        env_held     = gain[GAIN_BITS-1:0];
                        r.sample_out = apply_gain(smp, gain);
                        if (count_through(64'(dec_len)))
                            env_segment = SEG_SUSTAIN;
                    end
                    SEG_SUSTAIN: begin
                        gain         = sustain_cap();
                        env_held     = gain[GAIN_BITS-1:0];
                        r.sample_out = apply_gain(smp, gain);
                    end
                    SEG_RELEASE: begin
                        drop = (64'(env_count) * 64'(env_step)) >> GAIN_FRAC_BITS;
                        gain = (drop >= 64'(env_held)) ? '0 : 64'(env_held) - drop;
                        r.sample_out = apply_gain(smp, gain);
                        if (count_through(64'(rel_len)))
                            env_segment = SEG_IDLE;
                    end
                    default: begin
                        env_done = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
        r.voice_done = env_done;
        r.phase      = env_segment;
        return r;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] draw_length();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return 17'h0FFFF;
            2: return 17'($urandom_range(0, 65535));
            default: return 17'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] draw_sustain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 17'h10000;
            2: return 17'h1FFFF;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic int run_len(logic [LEN_BITS-1:0] len);
        return (len > RUN_CAP) ? RUN_CAP : int'(len);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic issue_event(input logic [OPCODE_BITS-1:0] op,
                               input logic [SAMPLE_BITS-1:0] smp,
                               input bit use_typed, input env_result_t typed);
        env_result_t due;
        int          gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_opcode    <= op;
        s_sample_in <= smp;
        do @(posedge aclk); while (!s_ready);
        due = envelope_step(op, smp);
        results_due.push_back(use_typed ? typed : due);
        if (op != OP_UNUSED)
            events_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val, input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ATTACK:  atk_len     = val[LEN_BITS-1:0];
            CFG_DECAY:   dec_len     = val[LEN_BITS-1:0];
            CFG_SUSTAIN: sustain_reg = val[GAIN_BITS-1:0];
            CFG_RELEASE: rel_len     = val[LEN_BITS-1:0];
            default: begin
            end
        endcase
        if (!keep_valid)
            cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    task automatic run_samples(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 11) == 0)
                issue_event(OPCODE_BITS'($urandom_range(0, 3)), draw_sample(), 1'b0, NO_RESULT);
            else
                issue_event(OP_SAMPLE, draw_sample(), 1'b0, NO_RESULT);
        end
    endtask

    initial begin
        int n;
        int phase_no;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].is_cfg) begin
                if (i == 0 || !DIRECTED[i-1].is_cfg)
                    drain_results();
                write_reg(DIRECTED[i].sel, DIRECTED[i].data,
                          (i + 1 < DIRECTED_ROWS) && DIRECTED[i+1].is_cfg);
            end else begin
                issue_event(DIRECTED[i].sel[OPCODE_BITS-1:0], DIRECTED[i].data[SAMPLE_BITS-1:0],
                            DIRECTED[i].typed_want, DIRECTED[i].want);
            end
        end

        phase_no = 0;
        while (events_sent < TARGET_EVENTS) begin
            drain_results();
            write_reg(CFG_ATTACK, draw_length(), 1'b1);
            write_reg(CFG_DECAY, draw_length(), 1'b1);
            write_reg(CFG_SUSTAIN, draw_sustain(), 1'b1);
            write_reg(CFG_RELEASE, draw_length(), 1'b0);
            no_gaps = (phase_no % 6 == 4);
            if (phase_no == 2 || phase_no == 9)
                rx_hold_req = 1'b1;
            repeat ($urandom_range(1, 3)) begin
                issue_event(OP_NOTE_ON, draw_sample(), 1'b0, NO_RESULT);
                n = run_len(atk_len) + run_len(dec_len) + $urandom_range(1, 4);
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(0, n);
                run_samples(n);
                issue_event(OP_NOTE_OFF, draw_sample(), 1'b0, NO_RESULT);
                n = run_len(rel_len) + $urandom_range(1, 4);
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(0, n);
                run_samples(n);
            end
            phase_no++;
        end
        no_gaps = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        env_result_t got;
        env_result_t want;
        int          stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 10);
            if (rx_hold_req) begin
                stall       = HOLD_CYCLES;
                rx_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_sample_out, m_voice_done, m_phase};
            if (results_due.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction %h/%b/%0d",
                                          got.sample_out, got.voice_done, got.phase));
            end else begin
                want = results_due.pop_front();
                if (got.sample_out !== want.sample_out)
                    report_mismatch($sformatf("sample_out got %h want %h",
                                              got.sample_out, want.sample_out));
                if (got.voice_done !== want.voice_done)
                    report_mismatch($sformatf("voice_done got %b want %b",
                                              got.voice_done, want.voice_done));
                if (got.phase !== want.phase)
                    report_mismatch($sformatf("phase got %0d want %0d",
                                              got.phase, want.phase));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

>>> sim.f
src/aeg_pkg.sv
src/aeg_divider.sv
src/aeg_datapath.sv
src/aeg_controller.sv
src/adsr_envelope_generator_core.sv
src/aeg_checker.sv
tb/testbench.sv
